### hdl/rbfr_pkg.sv
`timescale 1ns / 1ps

package rbfr_pkg;

  // Default store address width (store depth is 2^ADDR_BITS bytes)
  localparam int ADDR_BITS_DEFAULT = 10;

  // Width of intermediate sums of counters, lengths and offsets
  localparam int SUM_W = 18;

  // Fixed field widths
  localparam int MODE_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int OFFSET_W = 10;
  localparam int RLEN_W   = 16;
  localparam int USED_W   = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Command codes
  localparam logic [MODE_W-1:0] MODE_PUT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GET   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RPUT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RGET  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RLEN  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSKIP = 3'd6;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2    = 2'd1;

  localparam logic [3:0] SIZE_LOG2_RESET = 4'd10;

endpackage

### hdl/ring_byte_fifo_records_unit.sv
`timescale 1ns / 1ps

// Byte ring FIFO with optional length-prefixed records.
// Command channel: in_valid/in_ready carry mode, data_byte, last_byte and
// offset. Result channel: out_valid/out_ready carry ok, data_out,
// record_length, end_of_record and used_count; exactly one result per command.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 header
// bytes, 1 size log2) and empties the FIFO; write only while no command is
// in flight.
// From acceptance to result: put, clear, refused commands and non-final
// record bytes are decided in the accept cycle; get and peek first read the
// store; the final record byte writes the data byte, then one or two header
// bytes, one store write per cycle; a record get on an open record reads its
// next byte; a record get, length or skip that first has to read the header
// reads it (S_HLO, S_HHI) and evaluates it (S_HEV), a get then reading the
// first byte. The single write port and the registered store read set these.
// One command is worked at a time; the next command is taken as soon as the
// previous result sits in the output register, even while it is stalled.
// A result that the receiver stalls holds in the output register and the
// block waits in its push state. Reset empties the FIFO, selects plain mode
// with 1024 bytes in use; the store contents stay undefined until written.
module ring_byte_fifo_records_unit #(
  parameter int ADDR_BITS = rbfr_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rbfr_pkg::MODE_W-1:0]        mode,
  input  logic [rbfr_pkg::BYTE_W-1:0]        data_byte,
  input  logic                               last_byte,
  input  logic [rbfr_pkg::OFFSET_W-1:0]      offset,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               ok,
  output logic [rbfr_pkg::BYTE_W-1:0]        data_out,
  output logic [rbfr_pkg::RLEN_W-1:0]        record_length,
  output logic                               end_of_record,
  output logic [rbfr_pkg::USED_W-1:0]        used_count,
  input  logic                               cfg_we,
  input  logic [rbfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbfr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW    = ADDR_BITS + 1;
  localparam int DEPTH = 1 << ADDR_BITS;
  localparam int SW    = rbfr_pkg::SUM_W;
  localparam int BW    = rbfr_pkg::BYTE_W;
  localparam int RW    = rbfr_pkg::RLEN_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_EXEC = 9'b000000010,
    S_HLO  = 9'b000000100,
    S_HHI  = 9'b000001000,
    S_HEV  = 9'b000010000,
    S_RDAT = 9'b000100000,
    S_WH0  = 9'b001000000,
    S_WH1  = 9'b010000000,
    S_PUSH = 9'b100000000
  } state_t;

  function automatic logic [ADDR_BITS-1:0] ring_addr(input logic [SW-1:0] pos,
                                                     input logic [ADDR_BITS-1:0] m);
    ring_addr = pos[ADDR_BITS-1:0] & m;
  endfunction

  logic [BW-1:0] store [DEPTH];
  logic [BW-1:0] rd_data;

  state_t state, state_next;
  logic [CW-1:0] wc, wc_next, rc, rc_next;
  logic [RW-1:0] sc, sc_next, rem, rem_next;
  logic          dropped, dropped_next, open, open_next;
  logic [1:0]    hdr_reg;
  logic [3:0]    size_reg;

  logic [rbfr_pkg::MODE_W-1:0]   cmd_mode;
  logic [BW-1:0]                 cmd_din;
  logic                          cmd_last;
  logic [rbfr_pkg::OFFSET_W-1:0] cmd_off;
  logic [BW-1:0] hlo, hlo_next, hhi, hhi_next;

  logic          res_ok, res_ok_next, res_eor, res_eor_next;
  logic [BW-1:0] res_dout, res_dout_next;
  logic [RW-1:0] res_rlen, res_rlen_next;

  logic                 mem_we, mem_re;
  logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
  logic [BW-1:0]        mem_wdata;

  logic [1:0]           hlen;
  logic [4:0]           size_eff;
  logic [CW-1:0]        cap, used, free, avail, hdr_take;
  logic [ADDR_BITS-1:0] mask;
  logic [RW-1:0]        maxlen, hdr_val, hdr_n, rem_dec, sc_upd;
  logic                 fits, dropped_upd;

  logic in_fire, run_exec, push_go, cfg_hit;
  logic [rbfr_pkg::MODE_W-1:0]   c_mode;
  logic [BW-1:0]                 c_din;
  logic                          c_last;
  logic [rbfr_pkg::OFFSET_W-1:0] c_off;

  logic          fin, f_ok, f_eor;
  logic [BW-1:0] f_dout;
  logic [RW-1:0] f_rlen;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign run_exec = in_fire || (state == S_EXEC);
  assign push_go  = (state == S_PUSH) && (!out_valid || out_ready);
  assign cfg_hit  = cfg_we && ((cfg_index == rbfr_pkg::REG_HEADER_BYTES) ||
                               (cfg_index == rbfr_pkg::REG_SIZE_LOG2));

  // Command fields come straight from the ports in the accept cycle
  assign c_mode = (state == S_IDLE) ? mode      : cmd_mode;
  assign c_din  = (state == S_IDLE) ? data_byte : cmd_din;
  assign c_last = (state == S_IDLE) ? last_byte : cmd_last;
  assign c_off  = (state == S_IDLE) ? offset    : cmd_off;

  always_comb begin
    hlen = (hdr_reg == 2'd3) ? 2'd2 : hdr_reg;
    if (size_reg == 4'd0) begin
      size_eff = 5'd1;
    end else if (5'(size_reg) > 5'(ADDR_BITS)) begin
      size_eff = 5'(ADDR_BITS);
    end else begin
      size_eff = 5'(size_reg);
    end
    cap      = CW'(1) << size_eff;
    mask     = ADDR_BITS'(cap - CW'(1));
    used     = wc - rc;
    free     = (used >= cap) ? '0 : cap - used;
    maxlen   = (hlen == 2'd1) ? RW'(255) : {RW{1'b1}};
    fits     = ((SW'(hlen) + SW'(sc) + SW'(1)) <= SW'(free)) &&
               ((SW'(sc) + SW'(1)) <= SW'(maxlen));
    avail    = (used > CW'(hlen)) ? used - CW'(hlen) : '0;
    hdr_take = (used < CW'(hlen)) ? used : CW'(hlen);
    hdr_val  = {hhi, hlo};
    hdr_n    = (SW'(hdr_val) > SW'(avail)) ? RW'(avail) : hdr_val;
    rem_dec  = rem - RW'(1);
  end

  always_comb begin
    state_next    = state;
    wc_next       = wc;
    rc_next       = rc;
    sc_next       = sc;
    rem_next      = rem;
    dropped_next  = dropped;
    open_next     = open;
    hlo_next      = hlo;
    hhi_next      = hhi;
    res_ok_next   = res_ok;
    res_dout_next = res_dout;
    res_rlen_next = res_rlen;
    res_eor_next  = res_eor;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    fin           = 1'b0;
    f_ok          = 1'b0;
    f_dout        = '0;
    f_rlen        = '0;
    f_eor         = 1'b0;
    sc_upd        = sc;
    dropped_upd   = dropped;

    unique case (state) inside
      S_IDLE, S_EXEC: begin
        if (run_exec) begin
          if (c_mode == rbfr_pkg::MODE_CLEAR) begin
            wc_next      = '0;
            rc_next      = '0;
            sc_next      = '0;
            dropped_next = 1'b0;
            open_next    = 1'b0;
            rem_next     = '0;
            fin          = 1'b1;
            f_ok         = 1'b1;
          end else if (hlen == 2'd0) begin
            case (c_mode)
              rbfr_pkg::MODE_PUT: begin
                fin = 1'b1;
                if (free != '0) begin
                  mem_we    = 1'b1;
                  mem_waddr = ring_addr(SW'(wc), mask);
                  mem_wdata = c_din;
                  wc_next   = wc + CW'(1);
                  f_ok      = 1'b1;
                end
              end
              rbfr_pkg::MODE_GET: begin
                if (used != '0) begin
                  mem_re     = 1'b1;
                  mem_raddr  = ring_addr(SW'(rc), mask);
                  state_next = S_RDAT;
                end else begin
                  fin = 1'b1;
                end
              end
              rbfr_pkg::MODE_PEEK: begin
                if (SW'(c_off) < SW'(used)) begin
                  mem_re     = 1'b1;
                  mem_raddr  = ring_addr(SW'(rc) + SW'(c_off), mask);
                  state_next = S_RDAT;
                end else begin
                  fin = 1'b1;
                end
              end
              default: fin = 1'b1;
            endcase
          end else begin
            case (c_mode) inside
              rbfr_pkg::MODE_RPUT: begin
                if (!dropped) begin
                  if (!fits) begin
                    dropped_upd = 1'b1;
                  end else begin
                    mem_we    = 1'b1;
                    mem_waddr = ring_addr(SW'(wc) + SW'(hlen) + SW'(sc), mask);
                    mem_wdata = c_din;
                    sc_upd    = sc + RW'(1);
                  end
                end
                if (c_last) begin
                  dropped_next = 1'b0;
                  if (!dropped_upd) begin
                    sc_next    = sc_upd;
                    state_next = S_WH0;
                  end else begin
                    sc_next = '0;
                    fin     = 1'b1;
                  end
                end else begin
                  sc_next      = sc_upd;
                  dropped_next = dropped_upd;
                  fin          = 1'b1;
                  f_ok         = !dropped_upd;
                end
              end
              rbfr_pkg::MODE_RGET, rbfr_pkg::MODE_RLEN, rbfr_pkg::MODE_RSKIP: begin
                if (open) begin
                  if (c_mode == rbfr_pkg::MODE_RLEN) begin
                    fin    = 1'b1;
                    f_ok   = 1'b1;
                    f_rlen = rem;
                  end else if (c_mode == rbfr_pkg::MODE_RSKIP) begin
                    rc_next   = CW'(SW'(rc) + SW'(rem));
                    rem_next  = '0;
                    open_next = 1'b0;
                    fin       = 1'b1;
                    f_ok      = 1'b1;
                  end else if ((rem == '0) || (used == '0)) begin
                    rem_next  = '0;
                    open_next = 1'b0;
                    fin       = 1'b1;
                  end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = ring_addr(SW'(rc), mask);
                    state_next = S_RDAT;
                  end
                end else if (used != '0) begin
                  // fetch the length header first
                  mem_re     = 1'b1;
                  mem_raddr  = ring_addr(SW'(rc), mask);
                  state_next = S_HLO;
                end else begin
                  fin = 1'b1;
                end
              end
              default: fin = 1'b1;
            endcase
          end
        end
      end
      S_HLO: begin
        hlo_next = rd_data;
        if (hlen == 2'd2) begin
          mem_re     = 1'b1;
          mem_raddr  = ring_addr(SW'(rc) + SW'(1), mask);
          state_next = S_HHI;
        end else begin
          hhi_next   = '0;
          state_next = S_HEV;
        end
      end
      S_HHI: begin
        hhi_next   = rd_data;
        state_next = S_HEV;
      end
      S_HEV: begin
        case (cmd_mode)
          rbfr_pkg::MODE_RLEN: begin
            fin    = 1'b1;
            f_ok   = 1'b1;
            f_rlen = hdr_n;
          end
          rbfr_pkg::MODE_RSKIP: begin
            rc_next = CW'(SW'(rc) + SW'(hlen) + SW'(hdr_n));
            fin     = 1'b1;
            f_ok    = 1'b1;
          end
          default: begin
            // consume the header, open the record, then read its first byte
            rc_next    = rc + hdr_take;
            rem_next   = hdr_n;
            open_next  = 1'b1;
            state_next = S_EXEC;
          end
        endcase
      end
      S_RDAT: begin
        fin    = 1'b1;
        f_ok   = 1'b1;
        f_dout = rd_data;
        case (cmd_mode)
          rbfr_pkg::MODE_GET:  rc_next = rc + CW'(1);
          rbfr_pkg::MODE_PEEK: rc_next = rc;
          default: begin
            rc_next  = rc + CW'(1);
            rem_next = rem_dec;
            f_rlen   = rem_dec;
            if (rem_dec == '0) begin
              f_eor     = 1'b1;
              open_next = 1'b0;
            end
          end
        endcase
      end
      S_WH0, S_WH1: begin
        mem_we = 1'b1;
        if (state == S_WH0) begin
          mem_waddr = ring_addr(SW'(wc), mask);
          mem_wdata = sc[BW-1:0];
        end else begin
          mem_waddr = ring_addr(SW'(wc) + SW'(1), mask);
          mem_wdata = sc[RW-1:BW];
        end
        if ((state == S_WH0) && (hlen == 2'd2)) begin
          state_next = S_WH1;
        end else begin
          // commit the whole record, header included
          wc_next      = CW'(SW'(wc) + SW'(hlen) + SW'(sc));
          sc_next      = '0;
          dropped_next = 1'b0;
          fin          = 1'b1;
          f_ok         = 1'b1;
        end
      end
      S_PUSH: begin
        if (push_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (fin) begin
      state_next    = S_PUSH;
      res_ok_next   = f_ok;
      res_dout_next = f_dout;
      res_rlen_next = f_rlen;
      res_eor_next  = f_eor;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= store[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wc        <= '0;
      rc        <= '0;
      sc        <= '0;
      rem       <= '0;
      dropped   <= 1'b0;
      open      <= 1'b0;
      hdr_reg   <= 2'd0;
      size_reg  <= rbfr_pkg::SIZE_LOG2_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (push_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // a register write also empties the FIFO
      if (cfg_hit) begin
        if (cfg_index == rbfr_pkg::REG_HEADER_BYTES) begin
          hdr_reg <= cfg_data[1:0];
        end else begin
          size_reg <= cfg_data;
        end
        wc      <= '0;
        rc      <= '0;
        sc      <= '0;
        rem     <= '0;
        dropped <= 1'b0;
        open    <= 1'b0;
      end else begin
        wc      <= wc_next;
        rc      <= rc_next;
        sc      <= sc_next;
        rem     <= rem_next;
        dropped <= dropped_next;
        open    <= open_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_mode <= mode;
      cmd_din  <= data_byte;
      cmd_last <= last_byte;
      cmd_off  <= offset;
    end
    hlo      <= hlo_next;
    hhi      <= hhi_next;
    res_ok   <= res_ok_next;
    res_dout <= res_dout_next;
    res_rlen <= res_rlen_next;
    res_eor  <= res_eor_next;
    if (push_go) begin
      ok            <= res_ok;
      data_out      <= res_dout;
      record_length <= res_rlen;
      end_of_record <= res_eor;
      used_count    <= rbfr_pkg::USED_W'(used);
    end
  end

  a_used_le_cap: assert property (@(posedge clk) disable iff (rst)
    used <= cap)
    else $error("byte count exceeds capacity");

  a_open_record_mode: assert property (@(posedge clk) disable iff (rst)
    open |-> (hlen != 2'd0))
    else $error("record open in plain mode");

  a_remaining_held: assert property (@(posedge clk) disable iff (rst)
    open |-> (SW'(rem) <= SW'(used)))
    else $error("open record claims more bytes than held");

  a_staged_fits: assert property (@(posedge clk) disable iff (rst)
    (sc != '0) |-> ((SW'(hlen) + SW'(sc)) <= SW'(free)))
    else $error("staged record overruns free space");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire && !cfg_we |=> (state != S_IDLE))
    else $error("accepted transaction produced no work");

endmodule
